// File: rtl/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared constants and types of the five-point sharpen stream unit.
// ----------------------------------------------------------------------------
package sfp_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CHAN_W     = 3;
    localparam int IMG_W_W    = 12;
    localparam int IMG_H_W    = 13;
    localparam int TDATA_W    = 40;
    localparam int S_TDATA_W  = 8;

    localparam int DEF_MAX_WIDTH    = 2048;
    localparam int DEF_MAX_CHANNELS = 4;
    localparam int MAX_HEIGHT       = 4096;

    localparam logic [IMG_W_W-1:0] WIDTH_RESET  = IMG_W_W'(640);
    localparam logic [IMG_H_W-1:0] HEIGHT_RESET = IMG_H_W'(480);
    localparam logic [CHAN_W-1:0]  CHAN_RESET   = CHAN_W'(3);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    typedef struct packed {
        logic has_prev;  // a result for the row above is due
        logic is_last;   // the request lies in the last row of the frame
        logic inner;     // the row-above byte takes the full kernel
    } item_flags_t;

endpackage

// File: rtl/sfp_position.sv
// ----------------------------------------------------------------------------
// sfp_position
// Geometry registers, clamping and raster position tracking. Gives the
// position, line store addresses and result flags of the offered request.
// ----------------------------------------------------------------------------
module sfp_position #(
    parameter int MAX_WIDTH    = sfp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = sfp_pkg::DEF_MAX_CHANNELS,
    parameter int POS_W        = 13
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [sfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           advance,
    output logic [POS_W-1:0]               cur_col,
    output logic [sfp_pkg::ROW_W-1:0]      cur_row,
    output logic [POS_W-1:0]               addr_left,
    output logic [POS_W-1:0]               addr_right,
    output sfp_pkg::item_flags_t           flags
);
    import sfp_pkg::*;

    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int WCMP_W = (WID_W > IMG_W_W) ? WID_W : IMG_W_W;
    localparam int RB_W   = POS_W + 1;

    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;
    logic [CHAN_W-1:0]  chan_reg;
    logic [POS_W-1:0]   byte_pos_reg, byte_pos_next;
    logic [ROW_W-1:0]   row_pos_reg, row_pos_next;

    logic [WCMP_W-1:0]  w_ext, w_eff;
    logic [IMG_H_W-1:0] h_eff;
    logic [CHAN_W-1:0]  ch_eff;
    logic [RB_W-1:0]    row_bytes, col_ext, ch_ext, col_inc;
    logic [IMG_H_W-1:0] row_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            chan_reg   <= CHAN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:   width_reg  <= cfg_wdata[IMG_W_W-1:0];
                CFG_IMAGE_HEIGHT:  height_reg <= cfg_wdata[IMG_H_W-1:0];
                CFG_CHANNEL_COUNT: chan_reg   <= cfg_wdata[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_ext = WCMP_W'(width_reg);
        if (w_ext == '0) begin
            w_eff = WCMP_W'(1);
        end else if (w_ext > WCMP_W'(MAX_WIDTH)) begin
            w_eff = WCMP_W'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end

        if (height_reg == '0) begin
            h_eff = IMG_H_W'(1);
        end else if (height_reg > IMG_H_W'(MAX_HEIGHT)) begin
            h_eff = IMG_H_W'(MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end

        if (chan_reg == '0) begin
            ch_eff = CHAN_W'(1);
        end else if (chan_reg > CHAN_W'(MAX_CHANNELS)) begin
            ch_eff = CHAN_W'(MAX_CHANNELS);
        end else begin
            ch_eff = chan_reg;
        end

        ch_ext    = RB_W'(ch_eff);
        row_bytes = RB_W'(RB_W'(w_eff) * ch_ext);

        // A position left beyond a changed geometry restarts at zero.
        cur_col = (RB_W'(byte_pos_reg) >= row_bytes) ? '0 : byte_pos_reg;
        cur_row = (IMG_H_W'(row_pos_reg) >= h_eff) ? '0 : row_pos_reg;
        col_ext = RB_W'(cur_col);

        col_inc = col_ext + RB_W'(1);
        row_inc = IMG_H_W'(cur_row) + IMG_H_W'(1);
        if (col_inc >= row_bytes) begin
            byte_pos_next = '0;
            row_pos_next  = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            byte_pos_next = col_inc[POS_W-1:0];
            row_pos_next  = cur_row;
        end

        addr_right = POS_W'(col_ext + ch_ext);
        addr_left  = cur_col - POS_W'(ch_eff);

        flags.has_prev = (cur_row != '0);
        flags.is_last  = (row_inc == h_eff);
        flags.inner    = (cur_row >= ROW_W'(2)) && (w_eff > WCMP_W'(2)) &&
                         (col_ext >= ch_ext) && (col_ext < (row_bytes - ch_ext));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg <= '0;
            row_pos_reg  <= '0;
        end else if (advance) begin
            byte_pos_reg <= byte_pos_next;
            row_pos_reg  <= row_pos_next;
        end
    end

endmodule

// File: rtl/sfp_line_store.sv
// ----------------------------------------------------------------------------
// sfp_line_store
// The two row memories. Each is read at two addresses when a request is
// taken and written once when that request leaves the kernel stage.
// ----------------------------------------------------------------------------
module sfp_line_store #(
    parameter int POS_W = 13,
    parameter int DEPTH = 8192
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [POS_W-1:0]             rd_centre,
    input  logic [POS_W-1:0]             rd_left,
    input  logic [POS_W-1:0]             rd_right,
    input  logic                         wr_en,
    input  logic [sfp_pkg::SAMPLE_W-1:0] wr_sample,
    output logic [sfp_pkg::SAMPLE_W-1:0] centre,
    output logic [sfp_pkg::SAMPLE_W-1:0] left,
    output logic [sfp_pkg::SAMPLE_W-1:0] right,
    output logic [sfp_pkg::SAMPLE_W-1:0] up
);
    import sfp_pkg::*;

    logic [SAMPLE_W-1:0] older_mem [DEPTH];
    logic [SAMPLE_W-1:0] newer_mem [DEPTH];

    logic [SAMPLE_W-1:0] new_c_reg, new_r_reg, old_c_reg, old_l_reg;
    logic [POS_W-1:0]    addr_c_reg, addr_l_reg, addr_r_reg;
    logic [POS_W-1:0]    wr_addr_reg;
    logic [SAMPLE_W-1:0] wr_new_reg, wr_old_reg;
    logic                fwd_reg;
    logic                hit_c, hit_l, hit_r;

    // Reads and writes share an edge only for back-to-back requests, and then
    // the read misses the write just made; the held write data covers that.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            new_c_reg  <= newer_mem[rd_centre];
            new_r_reg  <= newer_mem[rd_right];
            old_c_reg  <= older_mem[rd_centre];
            old_l_reg  <= older_mem[rd_left];
            addr_c_reg <= rd_centre;
            addr_l_reg <= rd_left;
            addr_r_reg <= rd_right;
        end
        if (wr_en) begin
            newer_mem[addr_c_reg] <= wr_sample;
            older_mem[addr_c_reg] <= centre;
            wr_addr_reg           <= addr_c_reg;
            wr_new_reg            <= wr_sample;
            wr_old_reg            <= centre;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_reg <= wr_en;
        end
    end

    always_comb begin
        hit_c  = fwd_reg && (addr_c_reg == wr_addr_reg);
        hit_l  = fwd_reg && (addr_l_reg == wr_addr_reg);
        hit_r  = fwd_reg && (addr_r_reg == wr_addr_reg);
        centre = hit_c ? wr_new_reg : new_c_reg;
        right  = hit_r ? wr_new_reg : new_r_reg;
        up     = hit_c ? wr_old_reg : old_c_reg;
        left   = hit_l ? wr_old_reg : old_l_reg;
    end

endmodule

// File: rtl/sfp_out_stage.sv
// ----------------------------------------------------------------------------
// sfp_out_stage
// Kernel arithmetic with clamping, and the output register that holds the
// one or two results of a request until the stream side takes them.
// ----------------------------------------------------------------------------
module sfp_out_stage #(
    parameter int POS_W = 13
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         item_valid,
    input  sfp_pkg::item_flags_t         item_flags,
    input  logic [sfp_pkg::ROW_W-1:0]    item_row,
    input  logic [POS_W-1:0]             item_col,
    input  logic [sfp_pkg::SAMPLE_W-1:0] item_sample,
    input  logic [sfp_pkg::SAMPLE_W-1:0] centre,
    input  logic [sfp_pkg::SAMPLE_W-1:0] left,
    input  logic [sfp_pkg::SAMPLE_W-1:0] right,
    input  logic [sfp_pkg::SAMPLE_W-1:0] up,
    output logic                         item_take,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [sfp_pkg::TDATA_W-1:0]  m_tdata,   // value, out_row, out_column
    output logic                         m_tlast    // last_of_run
);
    import sfp_pkg::*;

    localparam int ACC_W = 12;

    logic [ACC_W-1:0]    centre5, neighbours, diff;
    logic [SAMPLE_W-1:0] sharp, val0;
    logic                load, stage_free, any_result;

    logic                p0_valid_reg, p1_valid_reg, last0_reg;
    logic [SAMPLE_W-1:0] val0_reg, val1_reg;
    logic [ROW_W-1:0]    row0_reg, row1_reg;
    logic [COL_W-1:0]    col_reg;

    always_comb begin
        centre5    = {2'b00, centre, 2'b00} + ACC_W'(centre);
        neighbours = ACC_W'(left) + ACC_W'(right) + ACC_W'(up) + ACC_W'(item_sample);
        diff       = centre5 - neighbours;
        if (centre5 < neighbours) begin
            sharp = '0;
        end else if (diff > ACC_W'(255)) begin
            sharp = '1;
        end else begin
            sharp = diff[SAMPLE_W-1:0];
        end
        val0 = item_flags.inner ? sharp : centre;

        any_result = item_flags.has_prev || item_flags.is_last;
        stage_free = !(p0_valid_reg || p1_valid_reg) ||
                     (m_tready && (p0_valid_reg != p1_valid_reg));
        item_take  = item_valid && (!any_result || stage_free);
        load       = item_take && any_result;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
        end else if (load) begin
            p0_valid_reg <= item_flags.has_prev;
            p1_valid_reg <= item_flags.is_last;
        end else if (m_tvalid && m_tready) begin
            if (p0_valid_reg) begin
                p0_valid_reg <= 1'b0;
            end else begin
                p1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            val0_reg  <= val0;
            row0_reg  <= item_row - ROW_W'(1);
            last0_reg <= !item_flags.is_last;
            val1_reg  <= item_sample;
            row1_reg  <= item_row;
            col_reg   <= COL_W'(item_col);
        end
    end

    always_comb begin
        m_tvalid = p0_valid_reg || p1_valid_reg;
        if (p0_valid_reg) begin
            m_tdata = {7'b0, col_reg, row0_reg, val0_reg};
            m_tlast = last0_reg;
        end else begin
            m_tdata = {7'b0, col_reg, row1_reg, val1_reg};
            m_tlast = 1'b1;
        end
    end

endmodule

// File: rtl/sharpen_five_point_stream_unit.sv
// ----------------------------------------------------------------------------
// sharpen_five_point_stream_unit
// Five-point cross sharpen over an interleaved byte stream in raster order,
// with two row memories holding the rows above the incoming one.
// ----------------------------------------------------------------------------
// A request passes the kernel stage, then the output register, before its results
// reach the master side. Throughput: one request per cycle while m_tready is high;
// a last-row request below row 0 gives two results and holds off the next.
// Reset clears geometry to 640 x 480 x 3, the raster position and the stage
// valids. The row memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module sharpen_five_point_stream_unit #(
    parameter int MAX_WIDTH    = sfp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = sfp_pkg::DEF_MAX_CHANNELS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [sfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sfp_pkg::S_TDATA_W-1:0]  s_tdata,   // sample
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sfp_pkg::TDATA_W-1:0]    m_tdata,   // value, out_row, out_column
    output logic                           m_tlast    // last_of_run
);
    import sfp_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int POS_W = $clog2(DEPTH);

    logic                accept, take;
    logic [POS_W-1:0]    cur_col, addr_left, addr_right;
    logic [ROW_W-1:0]    cur_row;
    item_flags_t         cur_flags;

    logic                s1_valid_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic [ROW_W-1:0]    s1_row_reg;
    logic [POS_W-1:0]    s1_col_reg;
    item_flags_t         s1_flags_reg;

    logic [SAMPLE_W-1:0] centre, left, right, up;

    assign s_tready = !s1_valid_reg || take;
    assign accept   = s_tvalid && s_tready;

    sfp_position #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .POS_W        (POS_W)
    ) u_position (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .advance    (accept),
        .cur_col    (cur_col),
        .cur_row    (cur_row),
        .addr_left  (addr_left),
        .addr_right (addr_right),
        .flags      (cur_flags)
    );

    sfp_line_store #(
        .POS_W (POS_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (accept),
        .rd_centre (cur_col),
        .rd_left   (addr_left),
        .rd_right  (addr_right),
        .wr_en     (take),
        .wr_sample (s1_sample_reg),
        .centre    (centre),
        .left      (left),
        .right     (right),
        .up        (up)
    );

    // Kernel stage: the request whose memory reads are under way.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (take) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_sample_reg <= s_tdata[SAMPLE_W-1:0];
            s1_row_reg    <= cur_row;
            s1_col_reg    <= cur_col;
            s1_flags_reg  <= cur_flags;
        end
    end

    sfp_out_stage #(
        .POS_W (POS_W)
    ) u_out_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (s1_valid_reg),
        .item_flags  (s1_flags_reg),
        .item_row    (s1_row_reg),
        .item_col    (s1_col_reg),
        .item_sample (s1_sample_reg),
        .centre      (centre),
        .left        (left),
        .right       (right),
        .up          (up),
        .item_take   (take),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

// File: tb/sharpen_five_point_stream_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sharpen_five_point_stream_unit_tb
// Streams frames of channel bytes through the sharpen unit and compares every
// result with a cycle-free software image of the filter that the testbench
// keeps alongside. It covers the kernel saturation cases, single-row and
// narrow frames, clamped register values, geometry changes part way through a
// frame, random idling on both channels and one long stall of the receiver.
// ----------------------------------------------------------------------------
module sharpen_five_point_stream_unit_tb;
    import sfp_pkg::*;

    localparam int STORE_DEPTH   = DEF_MAX_WIDTH * DEF_MAX_CHANNELS;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int SETTLE_LIMIT  = 5000;
    localparam int SETTLE_TAIL   = 8;
    localparam int HOLD_AT       = 600;
    localparam int HOLD_CYCLES   = 400;
    localparam int GEO_COUNT     = 12;

    typedef struct {
        logic [SAMPLE_W-1:0] value;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    column;
        logic                last;
    } pixel_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tlast;

    sharpen_five_point_stream_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // sample
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // value, out_row, out_column
        .m_tlast   (m_tlast)    // last_of_run
    );

    // Image of the block's registers and row memories.
    logic [IMG_W_W-1:0]  geo_width  = WIDTH_RESET;
    logic [IMG_H_W-1:0]  geo_height = HEIGHT_RESET;
    logic [CHAN_W-1:0]   geo_chan   = CHAN_RESET;
    logic [SAMPLE_W-1:0] older_row [STORE_DEPTH] = '{default: '0};
    logic [SAMPLE_W-1:0] newer_row [STORE_DEPTH] = '{default: '0};
    int                  raster_row = 0;
    int                  raster_col = 0;

    logic [SAMPLE_W-1:0] pending_samples [$];
    pixel_result_t       expected_pixels [$];
    pixel_result_t       oldest;

    logic s_acc = 1'b0;
    logic m_acc = 1'b0;
    bit   no_gaps = 1'b0;
    int   in_wait = 0;
    int   out_wait = 0;
    logic rx_hold = 1'b0;
    int   hold_left = 0;
    bit   hold_used = 1'b0;

    int requests_taken = 0;
    int results_checked = 0;
    int settings_used = 0;
    int errors = 0;

    int geo_table [GEO_COUNT][3] = '{
        '{3, 3, 1}, '{5, 4, 3}, '{2, 4, 2}, '{1, 3, 4}, '{0, 0, 0}, '{4, 6, 7},
        '{7, 5, 4}, '{8, 3, 3}, '{10, 4, 1}, '{3, 12, 2}, '{6, 2, 2}, '{12, 8, 4}
    };

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int frame_bytes();
        return clamp_int(int'(geo_width), 1, DEF_MAX_WIDTH)
             * clamp_int(int'(geo_height), 1, MAX_HEIGHT)
             * clamp_int(int'(geo_chan), 1, DEF_MAX_CHANNELS);
    endfunction

    // Works out the results that one accepted byte causes and advances the
    // raster position; the row above is finished while the next row arrives.
    function automatic void sharpen_byte(input logic [SAMPLE_W-1:0] smp);
        int w;
        int h;
        int ch;
        int row_bytes;
        int acc;
        bit inner;
        pixel_result_t res;
        w  = clamp_int(int'(geo_width), 1, DEF_MAX_WIDTH);
        h  = clamp_int(int'(geo_height), 1, MAX_HEIGHT);
        ch = clamp_int(int'(geo_chan), 1, DEF_MAX_CHANNELS);
        row_bytes = w * ch;
        if (raster_col >= row_bytes) raster_col = 0;
        if (raster_row >= h) raster_row = 0;
        if (raster_row >= 1) begin
            acc = int'(newer_row[raster_col]);
            inner = (raster_row >= 2) && (w > 2) && (raster_col >= ch)
                 && (raster_col < ch * (w - 1));
            if (inner) begin
                acc = 5 * acc - int'(older_row[raster_col - ch])
                    - int'(newer_row[raster_col + ch])
                    - int'(older_row[raster_col]) - int'(smp);
                acc = clamp_int(acc, 0, 255);
            end
            res.value  = SAMPLE_W'(acc);
            res.row    = ROW_W'(raster_row - 1);
            res.column = COL_W'(raster_col);
            res.last   = (raster_row + 1 != h);
            expected_pixels.push_back(res);
        end
        if (raster_row + 1 == h) begin
            res.value  = smp;
            res.row    = ROW_W'(raster_row);
            res.column = COL_W'(raster_col);
            res.last   = 1'b1;
            expected_pixels.push_back(res);
        end
        older_row[raster_col] = newer_row[raster_col];
        newer_row[raster_col] = smp;
        raster_col++;
        if (raster_col >= row_bytes) begin
            raster_col = 0;
            raster_row++;
            if (raster_row >= h) raster_row = 0;
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Sender: one request per queued byte, with a random pause after each unless no_gaps is set.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            in_wait = 0;
        end else if (!s_tvalid || s_acc) begin
            if (in_wait > 0) begin
                in_wait--;
                s_tvalid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                s_tdata  <= pending_samples.pop_front();
                s_tvalid <= 1'b1;
                in_wait = no_gaps ? 0 : $urandom_range(0, 5);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_acc <= 1'b0;
        end else begin
            s_acc <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                sharpen_byte(s_tdata);
                requests_taken++;
            end
        end
    end

    // One long stall of the receiver, so that the block backs up to its input.
    always @(negedge aclk) begin
        if (!hold_used && requests_taken >= HOLD_AT && pending_samples.size() != 0) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            rx_hold <= 1'b1;
        end else begin
            rx_hold <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            out_wait = 0;
        end else begin
            if (m_acc) out_wait = no_gaps ? 0 : $urandom_range(0, 5);
            if (rx_hold) begin
                m_tready <= 1'b0;
            end else if (out_wait > 0) begin
                out_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_acc <= 1'b0;
        end else begin
            m_acc <= m_tvalid && m_tready;
            if (m_tvalid && m_tready) begin
                results_checked++;
                if (expected_pixels.size() == 0) begin
                    $error("result with no request behind it: tdata %h", m_tdata);
                    errors++;
                end else begin
                    oldest = expected_pixels.pop_front();
                    check_field("value", int'(oldest.value), int'(m_tdata[7:0]));
                    check_field("out_row", int'(oldest.row), int'(m_tdata[19:8]));
                    check_field("out_column", int'(oldest.column), int'(m_tdata[32:20]));
                    check_field("last_of_run", int'(oldest.last), int'(m_tlast));
                    check_field("padding", 0, int'(m_tdata[TDATA_W-1:33]));
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        case (idx)
            CFG_IMAGE_WIDTH: begin
                geo_width = IMG_W_W'(val);
            end
            CFG_IMAGE_HEIGHT: begin
                geo_height = IMG_H_W'(val);
            end
            CFG_CHANNEL_COUNT: begin
                geo_chan = CHAN_W'(val);
            end
            default: begin
            end
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_geometry(input int w, input int h, input int ch);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_CHANNEL_COUNT, ch);
        settings_used++;
    endtask

    // Waits until every queued byte has gone in and every result has come out.
    task automatic settle();
        int spins;
        spins = 0;
        while (pending_samples.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_pixels.size() != 0 && spins < SETTLE_LIMIT) begin
            @(posedge aclk);
            spins++;
        end
        if (expected_pixels.size() != 0) begin
            $error("%0d expected results never arrived", expected_pixels.size());
            errors++;
            expected_pixels.delete();
        end
        repeat (SETTLE_TAIL) @(posedge aclk);
    endtask

    // Random bytes for a count of items: noise, a smooth surface around a random
    // base level, or black and white only.
    task automatic queue_random(input int count);
        int style;
        int base;
        style = $urandom_range(0, 2);
        base  = $urandom_range(20, 235);
        repeat (count) begin
            case (style)
                0: pending_samples.push_back(SAMPLE_W'($urandom_range(0, 255)));
                1: pending_samples.push_back(
                       SAMPLE_W'(clamp_int(base + $urandom_range(0, 16) - 8, 0, 255)));
                default: pending_samples.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
            endcase
        end
    endtask

    initial begin
        int random_requests;
        int phase;
        int frames;
        random_requests = 0;
        phase = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // A bright dot on black saturates high, a dark dot on white low.
        set_geometry(3, 3, 1);
        for (int i = 0; i < 9; i++) pending_samples.push_back(i == 4 ? 8'hFF : 8'h00);
        for (int i = 0; i < 9; i++) pending_samples.push_back(i == 4 ? 8'h00 : 8'hFF);
        settle();
        set_geometry(4, 1, 1);
        pending_samples.push_back(8'h55);
        pending_samples.push_back(8'hAA);
        pending_samples.push_back(8'h00);
        pending_samples.push_back(8'hFF);
        settle();

        // Narrowing the row part way through a row restarts it at column zero.
        set_geometry(6, 5, 2);
        queue_random(34);
        settle();
        write_reg(CFG_IMAGE_WIDTH, 4);
        queue_random(24);
        settle();
        // Lowering the height below the current row restarts the frame.
        queue_random(24);
        settle();
        write_reg(CFG_IMAGE_HEIGHT, 2);
        queue_random(16);
        settle();
        set_geometry(1, 8191, 1);
        queue_random(30);
        settle();
        write_reg(CFG_IMAGE_HEIGHT, 3);
        queue_random(9);
        settle();

        while (random_requests < RANDOM_ITEMS) begin
            if (phase < GEO_COUNT) begin
                set_geometry(geo_table[phase][0], geo_table[phase][1], geo_table[phase][2]);
            end else begin
                set_geometry($urandom_range(1, 12), $urandom_range(1, 8),
                             $urandom_range(0, 7));
            end
            no_gaps = ($urandom_range(0, 3) == 0);
            frames = $urandom_range(1, 3);
            repeat (frames) queue_random(frame_bytes());
            random_requests += frames * frame_bytes();
            settle();
            phase++;
        end

        $display("Run covered %0d requests and %0d results over %0d geometry settings,",
                 requests_taken, results_checked, settings_used);
        $display("with mid-frame geometry changes, clamped registers and a long stall.");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/sfp_pkg.sv
rtl/sfp_position.sv
rtl/sfp_line_store.sv
rtl/sfp_out_stage.sv
rtl/sharpen_five_point_stream_unit.sv
tb/sharpen_five_point_stream_unit_tb.sv
